@@ sv/visual_crypto_share_expander_unit_macros.svh @@
// Assertion macros for the share expander.
`ifndef VISUAL_CRYPTO_SHARE_EXPANDER_UNIT_MACROS_SVH
`define VISUAL_CRYPTO_SHARE_EXPANDER_UNIT_MACROS_SVH
`ifndef SYNTH
`define VCSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("share expander check failed");
`define VCSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("share expander check failed");
`else
`define VCSE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define VCSE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/vcse_pkg.sv @@
package vcse_pkg;

    localparam int MaxWidth   = 4096;
    localparam int CfgW       = 13;
    localparam int WidthA     = $clog2(MaxWidth) + 1;
    // Working width for pixel counts; wide enough for the register and the limit.
    localparam int WorkW      = (CfgW > WidthA) ? CfgW : WidthA;
    localparam int ColW       = (MaxWidth > 8) ? $clog2(MaxWidth / 8) : 1;
    localparam int QueueDepth = 2;
    localparam int QueueCntW  = $clog2(QueueDepth + 1);
    localparam int QueuePtrW  = $clog2(QueueDepth);

    localparam logic [CfgW-1:0] WidthReset = CfgW'(8);

    localparam logic OpKey   = 1'b0;
    localparam logic OpImage = 1'b1;

    localparam logic [1:0] StKeyTaken   = 2'd0;
    localparam logic [1:0] StShares     = 2'd1;
    localparam logic [1:0] StKeyDropped = 2'd2;
    localparam logic [1:0] StRefused    = 2'd3;

    typedef struct packed {
        logic       is_image;
        logic [7:0] data_byte;
    } t_item;

endpackage

@@ sv/vcse_front.sv @@
module vcse_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_opcode,
    input  logic [7:0]      i_data_byte,
    output logic            o_item_valid,
    input  logic            i_item_ready,
    output vcse_pkg::t_item o_item
);

    vcse_pkg::t_item                     r_mem [vcse_pkg::QueueDepth];
    logic [vcse_pkg::QueuePtrW-1:0]      r_wr_ptr;
    logic [vcse_pkg::QueuePtrW-1:0]      r_rd_ptr;
    logic [vcse_pkg::QueueCntW-1:0]      r_count;
    logic [vcse_pkg::QueuePtrW-1:0]      n_wr_ptr;
    logic [vcse_pkg::QueuePtrW-1:0]      n_rd_ptr;
    logic [vcse_pkg::QueueCntW-1:0]      n_count;
    logic                                push;
    logic                                pop;
    vcse_pkg::t_item                     in_item;

    assign o_in_ready   = (r_count != vcse_pkg::QueueCntW'(vcse_pkg::QueueDepth));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign push         = i_in_valid && o_in_ready;
    assign pop          = o_item_valid && i_item_ready;

    always_comb begin
        in_item.is_image  = (i_opcode == vcse_pkg::OpImage);
        in_item.data_byte = i_data_byte;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == vcse_pkg::QueuePtrW'(vcse_pkg::QueueDepth - 1))
                       ? '0 : r_wr_ptr + vcse_pkg::QueuePtrW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == vcse_pkg::QueuePtrW'(vcse_pkg::QueueDepth - 1))
                       ? '0 : r_rd_ptr + vcse_pkg::QueuePtrW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + vcse_pkg::QueueCntW'(1);
        end else if (pop && !push) begin
            n_count = r_count - vcse_pkg::QueueCntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_item;
        end
    end

endmodule

@@ sv/vcse_back.sv @@
module vcse_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [vcse_pkg::CfgW-1:0] i_cfg_data,
    input  logic                      i_item_valid,
    output logic                      o_item_ready,
    input  vcse_pkg::t_item           i_item,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_status,
    output logic [15:0]               o_share1_top,
    output logic [15:0]               o_share1_bottom,
    output logic [15:0]               o_share2_top,
    output logic [15:0]               o_share2_bottom,
    output logic                      o_low_byte_used,
    output logic                      o_row_end,
    output logic [4:0]                o_key_bits_held
);

    localparam int WW = vcse_pkg::WorkW;
    localparam int CW = vcse_pkg::ColW;

    logic [vcse_pkg::CfgW-1:0] r_width;
    logic [CW-1:0]             r_column;
    logic [15:0]               r_key_queue;
    logic [4:0]                r_key_count;
    logic                      r_out_valid;
    logic [1:0]                r_status;
    logic [15:0]               r_s1t;
    logic [15:0]               r_s1b;
    logic [15:0]               r_s2t;
    logic [15:0]               r_s2b;
    logic                      r_low_used;
    logic                      r_row_end;

    logic [CW-1:0]             n_column;
    logic [15:0]               n_key_queue;
    logic [4:0]                n_key_count;
    logic [1:0]                n_status;
    logic [15:0]               n_s1t;
    logic [15:0]               n_s1b;
    logic [15:0]               n_s2t;
    logic [15:0]               n_s2b;
    logic                      n_low_used;
    logic                      n_row_end;

    logic                      fire;
    logic [WW-1:0]             width_ext;
    logic [WW-1:0]             w_eff;
    logic [WW-1:0]             row_bytes;
    logic [CW-1:0]             col_eff;
    logic [WW-1:0]             remain;
    logic [3:0]                n_pix;
    logic                      last_col;
    logic [15:0]               key_ins;

    assign o_item_ready = !r_out_valid || i_out_ready;
    assign fire         = i_item_valid && o_item_ready;

    // Row geometry, with the width clamped into its legal range.
    always_comb begin
        width_ext = WW'(r_width);
        if (width_ext == '0) begin
            w_eff = WW'(1);
        end else if (width_ext > WW'(vcse_pkg::MaxWidth)) begin
            w_eff = WW'(vcse_pkg::MaxWidth);
        end else begin
            w_eff = width_ext;
        end
        row_bytes = (w_eff + WW'(7)) >> 3;
        col_eff   = (WW'(r_column) >= row_bytes) ? '0 : r_column;
        remain    = w_eff - WW'({col_eff, 3'b000});
        n_pix     = (remain > WW'(8)) ? 4'd8 : remain[3:0];
        last_col  = (WW'(col_eff) + WW'(1)) >= row_bytes;
        key_ins   = 16'({i_item.data_byte, 8'h00} >> r_key_count);
    end

    always_comb begin
        n_column    = r_column;
        n_key_queue = r_key_queue;
        n_key_count = r_key_count;
        n_status    = vcse_pkg::StKeyTaken;
        n_s1t       = '0;
        n_s1b       = '0;
        n_s2t       = '0;
        n_s2b       = '0;
        n_low_used  = 1'b0;
        n_row_end   = 1'b0;
        if (!i_item.is_image) begin
            if (r_key_count <= 5'd8) begin
                n_key_queue = r_key_queue | key_ins;
                n_key_count = r_key_count + 5'd8;
                n_status    = vcse_pkg::StKeyTaken;
            end else begin
                n_status    = vcse_pkg::StKeyDropped;
            end
        end else if (r_key_count < 5'(n_pix)) begin
            n_status = vcse_pkg::StRefused;
        end else begin
            // Each valid pixel of the byte takes the key bit at the same place from the head of the key queue.
            for (int k = 0; k < 8; k++) begin
                if (4'(k) < n_pix) begin
                    n_s1t[15-2*k] = !r_key_queue[15-k];
                    n_s1t[14-2*k] =  r_key_queue[15-k];
                    n_s1b[15-2*k] =  r_key_queue[15-k];
                    n_s1b[14-2*k] = !r_key_queue[15-k];
                    n_s2t[15-2*k] = !r_key_queue[15-k] ^ i_item.data_byte[7-k];
                    n_s2t[14-2*k] =  r_key_queue[15-k] ^ i_item.data_byte[7-k];
                    n_s2b[15-2*k] =  r_key_queue[15-k] ^ i_item.data_byte[7-k];
                    n_s2b[14-2*k] = !r_key_queue[15-k] ^ i_item.data_byte[7-k];
                end
            end
            n_key_queue = r_key_queue << n_pix;
            n_key_count = r_key_count - 5'(n_pix);
            n_low_used  = (n_pix > 4'd4);
            n_row_end   = last_col;
            n_column    = last_col ? '0 : CW'(col_eff + CW'(1));
            n_status    = vcse_pkg::StShares;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= vcse_pkg::WidthReset;
            r_column    <= '0;
            r_key_queue <= '0;
            r_key_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_data;
            end
            if (fire) begin
                r_column    <= n_column;
                r_key_queue <= n_key_queue;
                r_key_count <= n_key_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status   <= n_status;
            r_s1t      <= n_s1t;
            r_s1b      <= n_s1b;
            r_s2t      <= n_s2t;
            r_s2b      <= n_s2b;
            r_low_used <= n_low_used;
            r_row_end  <= n_row_end;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_share1_top    = r_s1t;
    assign o_share1_bottom = r_s1b;
    assign o_share2_top    = r_s2t;
    assign o_share2_bottom = r_s2b;
    assign o_low_byte_used = r_low_used;
    assign o_row_end       = r_row_end;
    assign o_key_bits_held = r_key_count;

`include "visual_crypto_share_expander_unit_macros.svh"

    `VCSE_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, 1'b1, r_key_count <= 5'd16)
    `VCSE_ASSERT_NEXT(a_refuse_keeps, i_clk, i_rst_n,
        fire && (n_status == vcse_pkg::StRefused),
        $stable(r_key_count) && $stable(r_key_queue) && $stable(r_column))
    `VCSE_ASSERT_IMPL(a_key_taken_cnt, i_clk, i_rst_n,
        r_out_valid && (r_status == vcse_pkg::StKeyTaken), r_key_count >= 5'd8)
    `VCSE_ASSERT_IMPL(a_row_end_col, i_clk, i_rst_n,
        r_out_valid && r_row_end, r_column == '0)

endmodule

@@ sv/visual_crypto_share_expander_unit.sv @@
// Flow: an accepted request is written into the request queue, and its result is loaded
// into the output register when the execute stage takes it from the queue.
// Throughput: one request per cycle while the output is taken, set by the execute stage
// behind a two-entry request queue; the output register frees as soon as it is taken.
// Reset (synchronous, active low) empties the queue and the output register,
// clears the key bits and the column, and sets the row width to eight pixels.
module visual_crypto_share_expander_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [vcse_pkg::CfgW-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_opcode,
    input  logic [7:0]                i_data_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_status,
    output logic [15:0]               o_share1_top,
    output logic [15:0]               o_share1_bottom,
    output logic [15:0]               o_share2_top,
    output logic [15:0]               o_share2_bottom,
    output logic                      o_low_byte_used,
    output logic                      o_row_end,
    output logic [4:0]                o_key_bits_held
);

    vcse_pkg::t_item item;
    logic            item_valid;
    logic            item_ready;

    vcse_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_data_byte  (i_data_byte),
        .o_item_valid (item_valid),
        .i_item_ready (item_ready),
        .o_item       (item)
    );

    vcse_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_item_valid    (item_valid),
        .o_item_ready    (item_ready),
        .i_item          (item),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_share1_top    (o_share1_top),
        .o_share1_bottom (o_share1_bottom),
        .o_share2_top    (o_share2_top),
        .o_share2_bottom (o_share2_bottom),
        .o_low_byte_used (o_low_byte_used),
        .o_row_end       (o_row_end),
        .o_key_bits_held (o_key_bits_held)
    );

endmodule
